[src/emcy_pkg.sv]
// ----------------------------------------------------------------------------
// emcy_pkg - shared types and constants
// Command/response item layouts, codes and sizing for the emergency sender.
// ----------------------------------------------------------------------------
`default_nettype none

package emcy_pkg;

	localparam int STACK_DEPTH = 8;
	localparam int QUEUE_DEPTH = 16;

	localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [31:0] COB_ID_RESET   = 32'd128;
	localparam int          COB_DIS_BIT    = 31;
	localparam int          COB_EXT_BIT    = 29;
	localparam logic [7:0]  GENERIC_ERROR  = 8'h01;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_TICK  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ZERO_CODE   = 2'd1,
		ST_STACK_FULL  = 2'd2,
		ST_QUEUE_FULL  = 2'd3
	} status_t;

	typedef enum logic {
		CFG_COB_ID  = 1'b0,
		CFG_INHIBIT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] error_code;
		logic [7:0]  error_register;
		logic [39:0] vendor_bytes;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic              frame_valid;
		logic [28:0]       frame_identifier;
		logic              frame_extended;
		logic [63:0]       frame_payload;
		logic [7:0]        register_now;
		logic [15:0]       top_code;
		logic [SCNT_W-1:0] stack_count;
	} rsp_t;

	typedef struct packed {
		logic        ext;
		logic [28:0] id;
		logic [63:0] payload;
	} frame_t;

	// Byte 0-1 code (LE), byte 2 register, bytes 3-7 vendor bytes
	function automatic logic [63:0] make_payload(input logic [15:0] code,
			input logic [7:0] err_reg, input logic [39:0] vendor);
		make_payload = {vendor, err_reg, code};
	endfunction

endpackage

`default_nettype wire

[src/emcy_ifs.sv]
// ----------------------------------------------------------------------------
// emcy_ifs - valid/ready channels
// Command and response channels of the emergency sender.
// ----------------------------------------------------------------------------
`default_nettype none

interface emcy_cmd_if;
	logic           valid;
	logic           ready;
	emcy_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface emcy_rsp_if;
	logic           valid;
	logic           ready;
	emcy_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/emergency_error_stack_and_frame_sender.sv]
// ----------------------------------------------------------------------------
// emergency_error_stack_and_frame_sender - emergency stack and frame queue
// Error stack with frame queue and inhibit-timed release, one command a cycle unless rsp stalls.
// ----------------------------------------------------------------------------
// Usage:
//   cmd: valid/ready channel carrying mode (push, pop, clear, 100 us tick)
//        with error code, error register bits and vendor bytes for a push.
//   rsp: valid/ready channel, exactly one response per command: status,
//        the frame released this command (if any), error register, top code
//        and stack depth.
//   cfg: cfg_we/cfg_index/cfg_wdata write the COB-ID word and inhibit time;
//        write only while no command is in flight.
// The response is registered at the edge that takes the command. Commands
// are taken one per cycle while rsp is not stalled; the stack shift, queue
// pointer update and inhibit countdown all update at that same edge.
// The response register frees on the transfer that drains it, so cmd.ready
// stays high while rsp.ready is high. When rsp stalls, one response is held
// and cmd.ready drops until it is taken.
// Reset empties the stack and frame queue, clears the countdown and error
// register, and loads the COB-ID with 0x80 and inhibit time with 0.
// ----------------------------------------------------------------------------
`default_nettype none

module emergency_error_stack_and_frame_sender (
	input  wire                clk,
	input  wire                arst_n,
	emcy_cmd_if.sink           cmd,
	emcy_rsp_if.source         rsp,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire [31:0]         cfg_wdata
);

	localparam int SD = emcy_pkg::STACK_DEPTH;
	localparam int QD = emcy_pkg::QUEUE_DEPTH;
	localparam int SW = emcy_pkg::SCNT_W;
	localparam int QW = emcy_pkg::QCNT_W;
	localparam int PW = emcy_pkg::QPTR_W;

	// configuration
	logic [31:0] cob_id_q;
	logic [15:0] inhibit_time_q;

	// state
	logic [15:0]            codes_q [SD];
	logic [7:0]             regs_q  [SD];
	logic [SW-1:0]          used_q;
	emcy_pkg::frame_t       qmem_q  [QD];
	logic [PW-1:0]          head_q, tail_q;
	logic [QW-1:0]          qcnt_q;
	logic [15:0]            inhibit_q;
	logic [7:0]             reg_held_q;

	logic                   rsp_valid_q;
	emcy_pkg::rsp_t         rsp_q;

	// next-state logic
	logic                   cmd_acc;
	logic [15:0]            codes_d [SD];
	logic [7:0]             regs_d  [SD];
	logic [SW-1:0]          used_d;
	logic                   send;
	logic [15:0]            snd_code;
	logic [7:0]             snd_reg;
	logic [39:0]            snd_vendor;
	logic [7:0]             push_reg;
	logic [15:0]            top_cur;
	logic [15:0]            top;
	emcy_pkg::status_t      status;
	logic                   tick;
	logic                   push_q;
	logic                   release_f;
	logic [15:0]            inh_t;
	emcy_pkg::frame_t       new_frame;
	emcy_pkg::frame_t       rel_frame;
	logic [QW-1:0]          qcnt_d;
	logic [15:0]            inhibit_d;
	logic [7:0]             reg_held_d;
	emcy_pkg::rsp_t         rsp_d;

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_comb begin
		for (int i = 0; i < SD; i++) begin
			codes_d[i] = codes_q[i];
			regs_d[i]  = regs_q[i];
		end
		used_d     = used_q;
		send       = 1'b0;
		snd_code   = '0;
		snd_reg    = '0;
		snd_vendor = '0;
		status     = emcy_pkg::ST_OK;
		tick       = 1'b0;
		top_cur    = (used_q != '0) ? codes_q[0] : 16'd0;
		top        = 16'd0;
		push_reg   = cmd.data.error_register | emcy_pkg::GENERIC_ERROR
			| ((used_q != '0) ? regs_q[0] : 8'd0);

		case (cmd.data.mode)
			emcy_pkg::MODE_PUSH: begin
				top = top_cur;
				if (cmd.data.error_code == 16'd0) begin
					status = emcy_pkg::ST_ZERO_CODE;
				end else if (used_q >= SW'(SD)) begin
					status = emcy_pkg::ST_STACK_FULL;
				end else begin
					for (int i = 1; i < SD; i++) begin
						codes_d[i] = codes_q[i-1];
						regs_d[i]  = regs_q[i-1];
					end
					codes_d[0] = cmd.data.error_code;
					regs_d[0]  = push_reg;
					used_d     = used_q + SW'(1);
					top        = cmd.data.error_code;
					send       = 1'b1;
					snd_code   = cmd.data.error_code;
					snd_reg    = push_reg;
					snd_vendor = cmd.data.vendor_bytes;
				end
			end
			emcy_pkg::MODE_POP: begin
				if (used_q != '0) begin
					top = codes_q[0];
					for (int i = 0; i < SD - 1; i++) begin
						codes_d[i] = codes_q[i+1];
						regs_d[i]  = regs_q[i+1];
					end
					used_d = used_q - SW'(1);
					send   = 1'b1;
					// new top goes out as register and vendor bytes 0-1
					if (used_q > SW'(1)) begin
						snd_reg    = regs_d[0];
						snd_vendor = {24'd0, codes_d[0]};
					end
				end
			end
			emcy_pkg::MODE_CLEAR: begin
				if (used_q != '0) begin
					used_d = '0;
					send   = 1'b1;
				end
			end
			emcy_pkg::MODE_TICK: begin
				top  = top_cur;
				tick = 1'b1;
			end
			default: begin
				top = top_cur;
			end
		endcase

		new_frame.ext     = cob_id_q[emcy_pkg::COB_EXT_BIT];
		new_frame.id      = cob_id_q[emcy_pkg::COB_EXT_BIT]
			? cob_id_q[28:0] : {18'd0, cob_id_q[10:0]};
		new_frame.payload = emcy_pkg::make_payload(snd_code, snd_reg, snd_vendor);

		push_q = 1'b0;
		if (send && !cob_id_q[emcy_pkg::COB_DIS_BIT]) begin
			if (qcnt_q >= QW'(QD)) begin
				status = emcy_pkg::ST_QUEUE_FULL;
			end else begin
				push_q = 1'b1;
			end
		end

		reg_held_d = send ? snd_reg : reg_held_q;

		inh_t     = (tick && inhibit_q != 16'd0) ? inhibit_q - 16'd1 : inhibit_q;
		release_f = (qcnt_q != '0 || push_q) && inh_t == 16'd0;
		// an empty queue releases the frame queued by this same command
		rel_frame = (qcnt_q == '0) ? new_frame : qmem_q[head_q];
		qcnt_d    = qcnt_q + QW'(push_q) - QW'(release_f);
		inhibit_d = release_f ? inhibit_time_q : inh_t;

		rsp_d.status           = status;
		rsp_d.frame_valid      = release_f;
		rsp_d.frame_identifier = release_f ? rel_frame.id : 29'd0;
		rsp_d.frame_extended   = release_f && rel_frame.ext;
		rsp_d.frame_payload    = release_f ? rel_frame.payload : 64'd0;
		rsp_d.register_now     = reg_held_d;
		rsp_d.top_code         = top;
		rsp_d.stack_count      = used_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cob_id_q       <= emcy_pkg::COB_ID_RESET;
			inhibit_time_q <= 16'd0;
		end else if (cfg_we) begin
			case (emcy_pkg::cfg_idx_t'(cfg_index))
				emcy_pkg::CFG_COB_ID:  cob_id_q       <= cfg_wdata;
				emcy_pkg::CFG_INHIBIT: inhibit_time_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			qcnt_q      <= '0;
			inhibit_q   <= 16'd0;
			reg_held_q  <= 8'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_acc) begin
				used_q     <= used_d;
				qcnt_q     <= qcnt_d;
				inhibit_q  <= inhibit_d;
				reg_held_q <= reg_held_d;
				if (push_q) begin
					tail_q <= (tail_q == PW'(QD - 1)) ? '0 : tail_q + PW'(1);
				end
				if (release_f) begin
					head_q <= (head_q == PW'(QD - 1)) ? '0 : head_q + PW'(1);
				end
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			for (int i = 0; i < SD; i++) begin
				codes_q[i] <= codes_d[i];
				regs_q[i]  <= regs_d[i];
			end
			if (push_q) begin
				qmem_q[tail_q] <= new_frame;
			end
			rsp_q <= rsp_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= SW'(SD))
		else $error("stack count above depth");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= QW'(QD))
		else $error("frame queue count above depth");

	a_inhibit_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && release_f |=> inhibit_q == $past(inhibit_time_q))
		else $error("countdown not reloaded after release");

	a_std_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.frame_extended |-> rsp_q.frame_identifier[28:11] == '0)
		else $error("11-bit identifier carries high bits");

	a_no_frame_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && qcnt_q != '0 && inh_t == 16'd0 |-> release_f)
		else $error("queued frame held with countdown at zero");
`endif

endmodule

`default_nettype wire
